// ----- rtl/sorted_key_table_assert.svh -----
// Assertion macros used by the sorted key table RTL.
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SKT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define SKT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/skt_pkg.sv -----
// Types and codes used by the sorted key table RTL.
`timescale 1ns / 1ps

package skt_pkg;

  typedef logic [1:0] action_t;
  typedef logic [2:0] status_t;
  typedef logic [6:0] pos_t;

  localparam action_t ActInsert = 2'd0;
  localparam action_t ActDelete = 2'd1;
  localparam action_t ActSearch = 2'd2;

  localparam status_t StInserted  = 3'd0;
  localparam status_t StDuplicate = 3'd1;
  localparam status_t StDeleted   = 3'd2;
  localparam status_t StFound     = 3'd3;
  localparam status_t StNotFound  = 3'd4;
  localparam status_t StEmpty     = 3'd5;
  localparam status_t StFull      = 3'd6;

  localparam int unsigned KeyW = 32;

  typedef struct packed {
    action_t                 action;
    logic signed [KeyW-1:0]  key;
  } in_item_t;

  typedef struct packed {
    status_t status;
    pos_t    position;
    pos_t    occupancy;
  } out_item_t;

endpackage

// ----- rtl/skt_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module skt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sorted_key_table.sv -----
// Top level of the sorted key table: a RAM-held ascending set of signed keys.
`timescale 1ns / 1ps
`include "sorted_key_table_assert.svh"

// The block holds up to CAPACITY distinct signed 32-bit keys in ascending order in
// a single RAM with one write port and one registered read port. Each input item
// asks to insert, delete or search one key, and each item yields exactly one result
// item carrying a status, the sorted position of the key where one applies, and the
// number of keys held afterwards. The block works on one item at a time. An item
// first runs a binary search over the held keys, in which each probe reads the RAM
// and then compares the read key, and it ends early when the key is hit. An insert
// then moves every larger key up by one entry, one entry per cycle through the RAM,
// writes the last moved key and then writes the new key; a delete moves every larger
// key down by one entry in the same way and writes the last moved key. The result
// then waits in the finishing state until the output register is free or draining,
// and the block takes the next item once it is idle again. Since keys move one entry
// at a time, a delete at the front of a full table, or an insert at the front of a
// nearly full one, is the slowest case. The output register lets the next item enter
// while an earlier result still waits to be taken. The RAM is never cleared: only
// entries below the key count are read, and those have always been written. Position
// and occupancy carry the low seven bits of their values.
module sorted_key_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  skt_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output skt_pkg::out_item_t  out_item_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;  // issue a probe or decide
  localparam logic [2:0] S_CMP  = 3'd2;  // compare the probed key
  localparam logic [2:0] S_MOVE = 3'd3;  // shift keys, one entry per cycle
  localparam logic [2:0] S_TAIL = 3'd4;  // write the last moved key
  localparam logic [2:0] S_PUT  = 3'd5;  // write the inserted key
  localparam logic [2:0] S_FIN  = 3'd6;  // hand the result to the output register

  logic [2:0]              state_q, state_d;
  logic [CW-1:0]           count_q, count_d;
  logic                    out_valid_q, out_valid_d;
  logic                    pend_q, pend_d;

  skt_pkg::action_t        action_q, action_d;
  logic signed [31:0]      key_q, key_d;
  logic [CW-1:0]           lo_q, lo_d;
  logic [CW-1:0]           hi_q, hi_d;
  logic                    hit_q, hit_d;
  logic [AW-1:0]           mid_q, mid_d;
  logic [AW-1:0]           ptr_q, ptr_d;
  logic [AW-1:0]           last_q, last_d;
  logic [AW-1:0]           waddr_q, waddr_d;
  logic                    up_q, up_d;
  skt_pkg::status_t        res_status_q, res_status_d;
  logic [CW-1:0]           res_pos_q, res_pos_d;
  skt_pkg::out_item_t      out_q, out_d;

  logic [CW:0]             sum_w;
  logic [AW-1:0]           mid_w;
  logic [CW-1:0]           count_next;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [31:0]             ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [31:0]             ram_rdata;

  // Midpoint of the remaining search window; while the window is not empty it lies below the key count.
  assign sum_w = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_w = sum_w[AW:1];

  always_comb begin
    count_next = count_q;
    if (res_status_q == skt_pkg::StInserted) begin
      count_next = count_q + CW'(1);
    end else if (res_status_q == skt_pkg::StDeleted) begin
      count_next = count_q - CW'(1);
    end
  end

  skt_ram #(
    .Width(32),
    .Depth(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    pend_d       = pend_q;
    action_d     = action_q;
    key_d        = key_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    hit_d        = hit_q;
    mid_d        = mid_q;
    ptr_d        = ptr_q;
    last_d       = last_q;
    waddr_d      = waddr_q;
    up_d         = up_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    out_d        = out_q;

    ram_we    = 1'b0;
    ram_waddr = waddr_q;
    ram_wdata = ram_rdata;
    ram_raddr = mid_w;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          action_d = in_item_i.action;
          key_d    = in_item_i.key;
          lo_d     = '0;
          hi_d     = count_q;
          hit_d    = 1'b0;
          state_d  = S_SRCH;
        end
      end

      S_SRCH: begin
        if ((lo_q < hi_q) && !hit_q) begin
          mid_d   = mid_w;
          state_d = S_CMP;
        end else begin
          // Search done: lo_q is the first entry not below the key.
          res_status_d = skt_pkg::StNotFound;
          res_pos_d    = '0;
          state_d      = S_FIN;
          case (action_q)
            skt_pkg::ActInsert: begin
              if (hit_q) begin
                res_status_d = skt_pkg::StDuplicate;
              end else if (count_q == CW'(CAPACITY)) begin
                res_status_d = skt_pkg::StFull;
              end else begin
                res_status_d = skt_pkg::StInserted;
                res_pos_d    = lo_q;
                if (lo_q == count_q) begin
                  state_d = S_PUT;
                end else begin
                  ptr_d   = AW'(count_q - CW'(1));
                  last_d  = lo_q[AW-1:0];
                  up_d    = 1'b1;
                  pend_d  = 1'b0;
                  state_d = S_MOVE;
                end
              end
            end
            skt_pkg::ActDelete: begin
              if (count_q == '0) begin
                res_status_d = skt_pkg::StEmpty;
              end else if (hit_q) begin
                res_status_d = skt_pkg::StDeleted;
                res_pos_d    = lo_q;
                if ((lo_q + CW'(1)) != count_q) begin
                  ptr_d   = AW'(lo_q + CW'(1));
                  last_d  = AW'(count_q - CW'(1));
                  up_d    = 1'b0;
                  pend_d  = 1'b0;
                  state_d = S_MOVE;
                end
              end
            end
            skt_pkg::ActSearch: begin
              if (hit_q) begin
                res_status_d = skt_pkg::StFound;
                res_pos_d    = lo_q;
              end
            end
            default: begin
              res_status_d = skt_pkg::StNotFound;
            end
          endcase
        end
      end

      S_CMP: begin
        if ($signed(ram_rdata) < key_q) begin
          lo_d = CW'(mid_q) + CW'(1);
        end else if ($signed(ram_rdata) == key_q) begin
          // Keys are distinct, so an equal probe is the lower bound itself.
          hit_d = 1'b1;
          lo_d  = CW'(mid_q);
          hi_d  = CW'(mid_q);
        end else begin
          hi_d = CW'(mid_q);
        end
        state_d = S_SRCH;
      end

      S_MOVE: begin
        ram_raddr = ptr_q;
        ram_we    = pend_q;
        pend_d    = 1'b1;
        if (up_q) begin
          waddr_d = ptr_q + AW'(1);
          ptr_d   = ptr_q - AW'(1);
        end else begin
          waddr_d = ptr_q - AW'(1);
          ptr_d   = ptr_q + AW'(1);
        end
        if (ptr_q == last_q) begin
          state_d = S_TAIL;
        end
      end

      S_TAIL: begin
        ram_we  = 1'b1;
        pend_d  = 1'b0;
        state_d = up_q ? S_PUT : S_FIN;
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q[AW-1:0];
        ram_wdata = key_q;
        state_d   = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.status    = res_status_q;
          out_d.position  = skt_pkg::pos_t'(res_pos_q);
          out_d.occupancy = skt_pkg::pos_t'(count_next);
          out_valid_d     = 1'b1;
          count_d         = count_next;
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q     <= action_d;
    key_q        <= key_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    hit_q        <= hit_d;
    mid_q        <= mid_d;
    ptr_q        <= ptr_d;
    last_q       <= last_d;
    waddr_q      <= waddr_d;
    up_q         <= up_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    out_q        <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // The key count never exceeds the table size.
  `SKT_ASSERT(a_count_range, count_q <= CW'(CAPACITY), "key count above capacity")

  // The RAM is written only while keys are moved or a new key is placed.
  `SKT_ASSERT(a_write_states, ram_we |-> (state_q == S_MOVE || state_q == S_TAIL || state_q == S_PUT), "RAM written outside a move or insert")

  // The key count changes only when a result is handed to the output register.
  `SKT_ASSERT(a_count_update, !$stable(count_q) |-> $past(state_q) == S_FIN, "key count changed outside result hand-over")

  // A result is loaded only into a free or draining output register.
  `SKT_ASSERT(a_no_overwrite, (out_valid_q && !out_ready_i) |=> $stable(out_q), "waiting result overwritten")

endmodule
